@@ hdl/masked_byte_pattern_scanner_assert.svh @@
// assertion macros for the masked byte pattern scanner
// used by the top level; expects clk and rst_n in scope
`ifndef MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MBPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbps same-cycle check failed");
`define MBPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbps next-cycle check failed");
`else
`define MBPS_ASSERT_IMP(lbl, ante, cons)
`define MBPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/mbps_pkg.sv @@
// shared types and constants for the masked byte pattern scanner
// no dependencies
package mbps_pkg;

    localparam int PAT_SLOTS       = 4;
    localparam int PATTERN_COUNT   = 4;
    localparam int MAX_PATTERN_LEN = 8;
    localparam int ADDR_W          = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int MASKS_W         = 48;
    localparam int FILL_W          = 3;
    localparam int LEN_W           = 4;
    localparam int FIELD_W         = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_0    = 3'd0,
        CFG_PATTERN_1    = 3'd1,
        CFG_PATTERN_2    = 3'd2,
        CFG_PATTERN_3    = 3'd3,
        CFG_MASKS_LENGTH = 3'd4,
        CFG_BASE_ADDRESS = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [PAT_SLOTS-1:0][CFG_DATA_W-1:0] pat_bytes;
        logic [MASKS_W-1:0]                   masks_lengths;
        logic [ADDR_W-1:0]                    base;
    } scan_cfg_t;

    typedef struct packed {
        logic [PAT_SLOTS-1:0]             hit;
        logic [PAT_SLOTS-1:0][ADDR_W-1:0] addr;
    } match_set_t;

endpackage

@@ hdl/masked_byte_pattern_scanner.sv @@
// masked byte pattern scanner, top level: input register, byte window, matcher, result drain
// path: input register, then result register, which drives the first result of an item
// throughput: one item per cycle unless stalled; multiple matches hold the result register
// reset: rst_n is asynchronous, active low; clears config, window, offset, fill and valids
// depends on mbps_pkg, mbps_config_regs, mbps_matcher, mbps_result_drain
`include "masked_byte_pattern_scanner_assert.svh"
module masked_byte_pattern_scanner #(
    parameter int PATTERN_COUNT   = mbps_pkg::PATTERN_COUNT,
    parameter int MAX_PATTERN_LEN = mbps_pkg::MAX_PATTERN_LEN
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data,
    // byte stream in
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         data_byte,
    input  logic                               last_byte,
    // match results out
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         pattern_index,
    output logic [mbps_pkg::ADDR_W-1:0]        match_address,
    output logic                               last_match
);

    localparam int WIN_SLOTS = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
    localparam logic [mbps_pkg::FILL_W-1:0] FILL_MAX =
        mbps_pkg::FILL_W'(MAX_PATTERN_LEN - 1);

    mbps_pkg::scan_cfg_t  cfg;
    mbps_pkg::match_set_t match_set;

    // input register stage
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       in_take;
    logic       advance;
    logic       drain_free;

    // scan state: previous bytes, offset of the byte in the input register, fill
    logic [WIN_SLOTS-1:0][7:0]       window_reg;
    logic [WIN_SLOTS-1:0][7:0]       window_next;
    logic [mbps_pkg::ADDR_W-1:0]     offset_reg;
    logic [mbps_pkg::ADDR_W-1:0]     offset_next;
    logic [mbps_pkg::FILL_W-1:0]     fill_reg;
    logic [mbps_pkg::FILL_W-1:0]     fill_next;

    mbps_config_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the item in the input register moves on when the result register is
    // empty or hands out its final result in this cycle
    assign advance  = s1_valid_reg && drain_free;
    assign in_stall = s1_valid_reg && !drain_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    // window shifts, offset and fill count up once the item leaves the input
    // register; the last byte of a region starts the next region clean
    always_comb
    begin
        window_next = window_reg;
        offset_next = offset_reg;
        fill_next   = fill_reg;
        if (advance)
        begin
            if (last_reg)
            begin
                window_next = '0;
                offset_next = '0;
                fill_next   = '0;
            end
            else
            begin
                for (int i = WIN_SLOTS - 1; i > 0; i--)
                begin
                    window_next[i] = window_reg[i-1];
                end
                window_next[0] = byte_reg;
                if (fill_reg < FILL_MAX)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                // offset saturates at the top of the address range
                if (offset_reg != '1)
                begin
                    offset_next = offset_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            offset_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            window_reg <= window_next;
            offset_reg <= offset_next;
            fill_reg   <= fill_next;
        end
    end

    // all signatures compared at once against the byte in the input register
    mbps_matcher #(
        .PATTERN_COUNT   (PATTERN_COUNT),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_match (
        .cfg       (cfg),
        .cur_byte  (byte_reg),
        .window    (window_reg),
        .fill      (fill_reg),
        .offset    (offset_reg),
        .match_set (match_set)
    );

    // result register, ordered by pattern index within one item
    mbps_result_drain u_drain (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .match_set     (match_set),
        .free          (drain_free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pattern_index (pattern_index),
        .match_address (match_address),
        .last_match    (last_match)
    );

    // a stalled input means an item is waiting in the input register
    `MBPS_ASSERT_IMP(a_stall_has_item, in_stall, s1_valid_reg)
    // the end of a region clears the scan state
    `MBPS_ASSERT_NXT(a_region_end_clears, advance && last_reg, offset_reg == '0 && fill_reg == '0)
    // the fill count never runs past the window depth
    `MBPS_ASSERT_IMP(a_fill_bounded, 1'b1, fill_reg <= FILL_MAX)
    // taking a result that is not the item's last leaves another one pending
    `MBPS_ASSERT_NXT(a_more_results, out_valid && !out_stall && !last_match, out_valid)

endmodule

@@ hdl/mbps_config_regs.sv @@
// configuration register file: four signatures, masks and lengths, base address
// depends on mbps_pkg
module mbps_config_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mbps_pkg::scan_cfg_t                cfg
);

    mbps_pkg::scan_cfg_t cfg_reg;
    mbps_pkg::scan_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (mbps_pkg::cfg_index_t'(cfg_index))
                mbps_pkg::CFG_PATTERN_0:    cfg_next.pat_bytes[0] = cfg_data;
                mbps_pkg::CFG_PATTERN_1:    cfg_next.pat_bytes[1] = cfg_data;
                mbps_pkg::CFG_PATTERN_2:    cfg_next.pat_bytes[2] = cfg_data;
                mbps_pkg::CFG_PATTERN_3:    cfg_next.pat_bytes[3] = cfg_data;
                mbps_pkg::CFG_MASKS_LENGTH:
                    cfg_next.masks_lengths = cfg_data[mbps_pkg::MASKS_W-1:0];
                mbps_pkg::CFG_BASE_ADDRESS:
                    cfg_next.base = cfg_data[mbps_pkg::ADDR_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/mbps_matcher.sv @@
// parallel signature compare over the byte window and start address math
// depends on mbps_pkg
module mbps_matcher #(
    parameter int PATTERN_COUNT   = mbps_pkg::PATTERN_COUNT,
    parameter int MAX_PATTERN_LEN = mbps_pkg::MAX_PATTERN_LEN,
    localparam int WIN_SLOTS      = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1
) (
    input  mbps_pkg::scan_cfg_t                 cfg,
    input  logic [7:0]                          cur_byte,
    input  logic [WIN_SLOTS-1:0][7:0]           window,
    input  logic [mbps_pkg::FILL_W-1:0]         fill,
    input  logic [mbps_pkg::ADDR_W-1:0]         offset,
    output mbps_pkg::match_set_t                match_set
);

    localparam int IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam logic [mbps_pkg::LEN_W-1:0] LEN_MAX = mbps_pkg::LEN_W'(MAX_PATTERN_LEN);

    logic [MAX_PATTERN_LEN-1:0][7:0] recent;

    // recent[0] is the current byte, recent[i] is i bytes back
    always_comb
    begin
        recent[0] = cur_byte;
        for (int i = 1; i < MAX_PATTERN_LEN; i++)
        begin
            recent[i] = window[i-1];
        end
    end

    always_comb
    begin
        logic [mbps_pkg::LEN_W-1:0] len;
        logic [7:0]                 cmp;
        logic [mbps_pkg::LEN_W-1:0] back;
        logic                       ok;
        match_set = '0;
        for (int k = 0; k < mbps_pkg::PAT_SLOTS; k++)
        begin
            len = cfg.masks_lengths[mbps_pkg::FIELD_W*k+8 +: mbps_pkg::LEN_W];
            cmp = cfg.masks_lengths[mbps_pkg::FIELD_W*k +: 8];
            ok  = (k < PATTERN_COUNT) && (len != '0) && (len <= LEN_MAX) &&
                  (len <= ({1'b0, fill} + 4'd1));
            for (int j = 0; j < MAX_PATTERN_LEN; j++)
            begin
                back = len - 4'd1 - mbps_pkg::LEN_W'(j);
                // wildcard bytes and bytes past the length are skipped
                if ((mbps_pkg::LEN_W'(j) < len) && cmp[j] &&
                    (recent[back[IDX_W-1:0]] != cfg.pat_bytes[k][8*j +: 8]))
                begin
                    ok = 1'b0;
                end
            end
            match_set.hit[k]  = ok;
            match_set.addr[k] = cfg.base + offset -
                                (mbps_pkg::ADDR_W'(len) - mbps_pkg::ADDR_W'(1));
        end
    end

endmodule

@@ hdl/mbps_result_drain.sv @@
// result register: holds the matches of one item and hands them out one per cycle unless out_stall holds them
// depends on mbps_pkg
module mbps_result_drain (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  mbps_pkg::match_set_t            match_set,
    output logic                            free,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      pattern_index,
    output logic [mbps_pkg::ADDR_W-1:0]     match_address,
    output logic                            last_match
);

    logic [mbps_pkg::PAT_SLOTS-1:0]                      hit_reg;
    logic [mbps_pkg::PAT_SLOTS-1:0]                      hit_next;
    logic [mbps_pkg::PAT_SLOTS-1:0][mbps_pkg::ADDR_W-1:0] addr_reg;
    logic [mbps_pkg::PAT_SLOTS-1:0]                      hit_rest;
    logic                                                taken;
    logic [1:0]                                          sel;

    // lowest pending pattern goes first
    always_comb
    begin
        sel = '0;
        for (int k = mbps_pkg::PAT_SLOTS - 1; k >= 0; k--)
        begin
            if (hit_reg[k])
            begin
                sel = 2'(k);
            end
        end
    end

    assign hit_rest      = hit_reg & (hit_reg - 1'b1);
    assign out_valid     = |hit_reg;
    assign taken         = out_valid && !out_stall;
    assign last_match    = (hit_rest == '0);
    assign pattern_index = sel;
    assign match_address = addr_reg[sel];
    assign free          = !out_valid || (taken && last_match);

    always_comb
    begin
        hit_next = hit_reg;
        if (load)
        begin
            hit_next = match_set.hit;
        end
        else if (taken)
        begin
            hit_next = hit_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= match_set.addr;
        end
    end

endmodule
